// ----- sv/sid_pkg.sv -----
`default_nettype none
package sid_pkg;

  localparam int COORD_BITS  = 24;
  localparam int T_FRAC_BITS = 16;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int REM_W  = SUM_W + 1;
  localparam int T_W    = T_FRAC_BITS + 1;
  localparam int LP_W   = DIFF_W + T_W;

  localparam int MIN_LEN_W  = 40;
  localparam int MARGIN_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;
  localparam int CMP_W      = ((T_W > MARGIN_W) ? T_W : MARGIN_W) + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN_SQ = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_T_MARGIN   = CFG_IDX_W'(1);

  localparam logic [T_W-1:0]  T_ONE  = T_W'(1) << T_FRAC_BITS;
  localparam logic [LP_W-1:0] T_HALF = LP_W'(1) << (T_FRAC_BITS - 1);

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_DEGEN    = 2'd1,
    ST_PARALLEL = 2'd2,
    ST_OUTSIDE  = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] first_start_x;
    logic signed [COORD_BITS-1:0] first_start_y;
    logic signed [COORD_BITS-1:0] first_end_x;
    logic signed [COORD_BITS-1:0] first_end_y;
    logic signed [COORD_BITS-1:0] second_start_x;
    logic signed [COORD_BITS-1:0] second_start_y;
    logic signed [COORD_BITS-1:0] second_end_x;
    logic signed [COORD_BITS-1:0] second_end_y;
  } in_t;

  typedef struct packed {
    status_e                      status;
    logic [T_W-1:0]               t_first;
    logic [T_W-1:0]               t_second;
    logic signed [COORD_BITS-1:0] cross_x;
    logic signed [COORD_BITS-1:0] cross_y;
  } out_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [DIFF_W-1:0]     ux;
    logic signed [DIFF_W-1:0]     uy;
  } pass_t;

  typedef struct packed {
    status_e                st;
    logic [REM_W-1:0]       d;
    logic [REM_W-1:0]       tr;
    logic [REM_W-1:0]       sr;
    logic [T_FRAC_BITS-1:0] tq;
    logic [T_FRAC_BITS-1:0] sq;
    logic                   teq;
    logic                   seq;
    pass_t                  p;
  } div_t;

endpackage
`default_nettype wire

// ----- sv/sid_div_step.sv -----
`default_nettype none
module sid_div_step (
  input  logic          clk_i,
  input  logic          en_i,
  input  sid_pkg::div_t div_i,
  output sid_pkg::div_t div_o
);
  import sid_pkg::*;

  div_t             div_d, div_q;
  logic [REM_W-1:0] tr2, sr2;

  always_comb begin
    div_d = div_i;
    tr2 = {div_i.tr[REM_W-2:0], 1'b0};
    sr2 = {div_i.sr[REM_W-2:0], 1'b0};
    div_d.tq = {div_i.tq[T_FRAC_BITS-2:0], (tr2 >= div_i.d)};
    div_d.sq = {div_i.sq[T_FRAC_BITS-2:0], (sr2 >= div_i.d)};
    div_d.tr = (tr2 >= div_i.d) ? tr2 - div_i.d : tr2;
    div_d.sr = (sr2 >= div_i.d) ? sr2 - div_i.d : sr2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;
endmodule
`default_nettype wire

// ----- sv/segment_intersect_2d_core.sv -----
`default_nettype none
// 2d segment intersection, fully pipelined, no state between beats.
// input channel: in_valid_i / in_stall_o with in_data_i holding segments a-b
// and c-d as signed q15.8. output channel: out_valid_o / out_stall_i with
// out_data_o holding status, t_first, t_second (q1.16) and the crossing point.
// a beat is taken at a clock edge with valid high and stall low.
// the stages are differences, products, sums, sign fix, one restoring
// divider step per quotient bit, margin check with lerp multiply, round
// and add. throughput is one beat per cycle while the output is not
// stalled; the quotient bits come from a chain of divider stages, one
// bit each, so items overlap in flight.
// when the output is stalled with a valid result, the whole pipe holds and
// in_stall_o goes high; nothing is lost or repeated.
// config: cfg_valid_i / cfg_ready_o (always ready), index 0 min_len_sq,
// index 1 t_margin; write only while the pipe is empty.
// reset clears all valid bits and sets both registers to 1.
module segment_intersect_2d_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  sid_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output sid_pkg::out_t                out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sid_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sid_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sid_pkg::*;

  localparam int NST = 6 + T_FRAC_BITS;

  logic [MIN_LEN_W-1:0] min_len_q;
  logic [MARGIN_W-1:0]  margin_q;
  logic [NST-1:0]       v_q;
  logic                 adv;

  assign cfg_ready_o = 1'b1;
  assign adv = !v_q[NST-1] || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MIN_LEN_W'(1);
      margin_q <= MARGIN_W'(1);
      v_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_index_i == CFG_MIN_LEN_SQ) begin
        min_len_q <= cfg_data_i[MIN_LEN_W-1:0];
      end
      if (cfg_valid_i && cfg_index_i == CFG_T_MARGIN) begin
        margin_q <= cfg_data_i[MARGIN_W-1:0];
      end
      if (adv) begin
        v_q <= {v_q[NST-2:0], in_valid_i};
      end
    end
  end

  // stage 1: differences
  logic signed [DIFF_W-1:0] vx1_q, vy1_q, wx1_q, wy1_q;
  pass_t p1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q.ax <= in_data_i.first_start_x;
      p1_q.ay <= in_data_i.first_start_y;
      p1_q.ux <= DIFF_W'(in_data_i.first_end_x) - DIFF_W'(in_data_i.first_start_x);
      p1_q.uy <= DIFF_W'(in_data_i.first_end_y) - DIFF_W'(in_data_i.first_start_y);
      vx1_q <= DIFF_W'(in_data_i.second_end_x) - DIFF_W'(in_data_i.second_start_x);
      vy1_q <= DIFF_W'(in_data_i.second_end_y) - DIFF_W'(in_data_i.second_start_y);
      wx1_q <= DIFF_W'(in_data_i.first_start_x) - DIFF_W'(in_data_i.second_start_x);
      wy1_q <= DIFF_W'(in_data_i.first_start_y) - DIFF_W'(in_data_i.second_start_y);
    end
  end

  // stage 2: products
  logic signed [PROD_W-1:0] uxx_q, uyy_q, vxx_q, vyy_q;
  logic signed [PROD_W-1:0] d1_q, d2_q, t1_q, t2_q, s1_q, s2_q;
  pass_t p2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_q <= p1_q;
      uxx_q <= p1_q.ux * p1_q.ux;
      uyy_q <= p1_q.uy * p1_q.uy;
      vxx_q <= vx1_q * vx1_q;
      vyy_q <= vy1_q * vy1_q;
      d1_q <= p1_q.uy * vx1_q;
      d2_q <= p1_q.ux * vy1_q;
      t1_q <= wx1_q * vy1_q;
      t2_q <= wy1_q * vx1_q;
      s1_q <= wx1_q * p1_q.uy;
      s2_q <= wy1_q * p1_q.ux;
    end
  end

  // stage 3: sums
  logic [SUM_W-1:0]        ulen_q, vlen_q;
  logic signed [SUM_W-1:0] den_q, tn_q, sn_q;
  pass_t p3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p3_q <= p2_q;
      ulen_q <= SUM_W'(unsigned'(uxx_q)) + SUM_W'(unsigned'(uyy_q));
      vlen_q <= SUM_W'(unsigned'(vxx_q)) + SUM_W'(unsigned'(vyy_q));
      den_q <= SUM_W'(d1_q) - SUM_W'(d2_q);
      tn_q <= SUM_W'(t1_q) - SUM_W'(t2_q);
      sn_q <= SUM_W'(s1_q) - SUM_W'(s2_q);
    end
  end

  // stage 4: sign fix, class checks, divider seed
  div_t div_s [0:T_FRAC_BITS];
  div_t div0_d, div0_q;
  logic signed [SUM_W-1:0] dn, tn2, sn2;
  logic degen, par, outr;

  always_comb begin
    dn  = den_q[SUM_W-1] ? -den_q : den_q;
    tn2 = den_q[SUM_W-1] ? -tn_q : tn_q;
    sn2 = den_q[SUM_W-1] ? -sn_q : sn_q;
    degen = (ulen_q < min_len_q) || (vlen_q < min_len_q);
    par = (den_q == '0);
    outr = tn2[SUM_W-1] || (tn2 > dn) || sn2[SUM_W-1] || (sn2 > dn);
    if (degen) begin
      div0_d.st = ST_DEGEN;
    end else if (par) begin
      div0_d.st = ST_PARALLEL;
    end else if (outr) begin
      div0_d.st = ST_OUTSIDE;
    end else begin
      div0_d.st = ST_HIT;
    end
    div0_d.d = REM_W'(unsigned'(dn));
    div0_d.tr = outr ? '0 : REM_W'(unsigned'(tn2));
    div0_d.sr = outr ? '0 : REM_W'(unsigned'(sn2));
    div0_d.tq = '0;
    div0_d.sq = '0;
    div0_d.teq = (tn2 == dn);
    div0_d.seq = (sn2 == dn);
    div0_d.p = p3_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div0_q <= div0_d;
    end
  end

  assign div_s[0] = div0_q;

  for (genvar k = 0; k < T_FRAC_BITS; k++) begin : g_div
    sid_div_step u_step (
      .clk_i (clk_i),
      .en_i  (adv),
      .div_i (div_s[k]),
      .div_o (div_s[k+1])
    );
  end

  // margin check and lerp multiply
  div_t dv;
  logic [T_W-1:0]        qt, qs;
  logic [CMP_W-1:0]      qt_c, qs_c, m_c, lim_c;
  logic                  tin, sin;
  logic [DIFF_W-1:0]     magx, magy;
  status_e               st_f_q;
  logic [T_W-1:0]        qt_q, qs_q;
  logic [LP_W-1:0]       prx_q, pry_q;
  logic signed [COORD_BITS-1:0] ax_q, ay_q;
  logic                  nx_q, ny_q;

  always_comb begin
    dv = div_s[T_FRAC_BITS];
    qt = dv.teq ? T_ONE : {1'b0, dv.tq};
    qs = dv.seq ? T_ONE : {1'b0, dv.sq};
    qt_c = CMP_W'(qt);
    qs_c = CMP_W'(qs);
    m_c = CMP_W'(margin_q);
    lim_c = CMP_W'(T_ONE);
    tin = ((qt_c > m_c) || (qt_c == m_c && !dv.teq && dv.tr != '0)) && (qt_c + m_c < lim_c);
    sin = ((qs_c > m_c) || (qs_c == m_c && !dv.seq && dv.sr != '0)) && (qs_c + m_c < lim_c);
    magx = dv.p.ux[DIFF_W-1] ? unsigned'(-dv.p.ux) : unsigned'(dv.p.ux);
    magy = dv.p.uy[DIFF_W-1] ? unsigned'(-dv.p.uy) : unsigned'(dv.p.uy);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (dv.st == ST_HIT) begin
        st_f_q <= (tin && sin) ? ST_HIT : ST_OUTSIDE;
      end else begin
        st_f_q <= dv.st;
      end
      qt_q <= qt;
      qs_q <= qs;
      prx_q <= LP_W'(magx) * LP_W'(qt);
      pry_q <= LP_W'(magy) * LP_W'(qt);
      ax_q <= dv.p.ax;
      ay_q <= dv.p.ay;
      nx_q <= dv.p.ux[DIFF_W-1];
      ny_q <= dv.p.uy[DIFF_W-1];
    end
  end

  // round, add and output register
  logic [LP_W-1:0]   offx, offy;
  logic [DIFF_W-1:0] cx, cy;
  out_t out_d, out_q;

  always_comb begin
    offx = (prx_q + T_HALF) >> T_FRAC_BITS;
    offy = (pry_q + T_HALF) >> T_FRAC_BITS;
    cx = nx_q ? DIFF_W'(ax_q) - offx[DIFF_W-1:0] : DIFF_W'(ax_q) + offx[DIFF_W-1:0];
    cy = ny_q ? DIFF_W'(ay_q) - offy[DIFF_W-1:0] : DIFF_W'(ay_q) + offy[DIFF_W-1:0];
    out_d.status = st_f_q;
    if (st_f_q == ST_HIT) begin
      out_d.t_first = qt_q;
      out_d.t_second = qs_q;
      out_d.cross_x = signed'(cx[COORD_BITS-1:0]);
      out_d.cross_y = signed'(cy[COORD_BITS-1:0]);
    end else begin
      out_d.t_first = '0;
      out_d.t_second = '0;
      out_d.cross_x = '0;
      out_d.cross_y = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v_q[NST-1];
  assign out_data_o = out_q;
endmodule
`default_nettype wire
